// ===== src/swmp_pkg.sv =====
// shared types and constants of the sliding window mean and peak block
`default_nettype none
package swmp_pkg;

  localparam int WINDOW_MAX_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS       = 8;
  localparam int LEN_BITS        = 6;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 6'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP_RD,
    ST_DROP_SUB,
    ST_WRITE,
    ST_PEAK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    mem_we;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== src/swmp_ring.sv =====
// sample ring memory, one write and one registered read per cycle
`default_nettype none
module swmp_ring #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/swmp_alu.sv =====
// shared add/subtract unit with carry or borrow out
`default_nettype none
module swmp_alu #(
  parameter int W = 22
) (
  input  wire swmp_pkg::alu_op_t op,
  input  wire logic [W-1:0]      a,
  input  wire logic [W-1:0]      b,
  output logic      [W-1:0]      y,
  output logic                   co
);
  import swmp_pkg::*;

  logic [W:0] sum;

  always_comb begin
    unique case (op)
      ALU_ADD: sum = {1'b0, a} + {1'b0, b};
      ALU_SUB: sum = {1'b0, a} - {1'b0, b};
      default: sum = '0;
    endcase
  end

  // for subtraction the top bit is the borrow, i.e. a < b
  assign y  = sum[W-1:0];
  assign co = sum[W];

endmodule
`default_nettype wire

// ===== src/sliding_window_mean_peak.sv =====
// sliding window mean and peak: sequencer, ring memory and shared add/subtract unit
// per word: accept, write to the ring, peak walk, divide for the mean, then the result word,
//   and when the window is full the oldest sample is read back and removed first;
//   the peak walk reads one ring entry per cycle, the mean takes one divide step per cycle
// throughput: no new word taken while one is at work
// reset: synchronous active low; window empty, window_length 5, no clearing pass needed
`default_nettype none
module sliding_window_mean_peak #(
  parameter int WINDOW_MAX  = swmp_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swmp_pkg::SAMPLE_BITS_DEF,
  localparam int CW     = $clog2(WINDOW_MAX + 1),
  localparam int MW     = SAMPLE_BITS + swmp_pkg::FRAC_BITS,
  localparam int IN_TW  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OF     = CW + MW + 3 * SAMPLE_BITS,
  localparam int OUT_TW = ((OF + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [swmp_pkg::LEN_BITS-1:0] cfg_data,   // window_length
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [IN_TW-1:0]              in_tdata,   // sample
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [OUT_TW-1:0]             out_tdata   // count, mean_fixed, peak_value,
                                                         // oldest_value, newest_value
);
  import swmp_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int TW = SAMPLE_BITS + CW;
  localparam int DW = TW + FRAC_BITS;
  localparam int SW = $clog2(DW);
  localparam int PW = CW + 1;
  localparam int EW = (LEN_BITS > CW) ? LEN_BITS : CW;

  function automatic logic [AW-1:0] wrap_idx(input logic [PW-1:0] s);
    logic [PW-1:0] d;
    d = s - PW'(WINDOW_MAX);
    if (s >= PW'(WINDOW_MAX)) begin
      return d[AW-1:0];
    end
    return s[AW-1:0];
  endfunction

  state_t state_r, state_nxt;
  ctrl_t  ctrl;

  logic [LEN_BITS-1:0]    len_r;
  logic [AW-1:0]          head_r;
  logic [CW-1:0]          fill_r;
  logic [TW-1:0]          total_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] peak_r;
  logic [SAMPLE_BITS-1:0] oldest_r;
  logic [CW-1:0]          issue_r;
  logic                   pend_r;
  logic                   first_r;
  logic [CW-1:0]          rem_r;
  logic [DW-1:0]          q_r;
  logic [SW-1:0]          step_r;
  logic                   out_valid_r;
  logic [OF-1:0]          out_data_r;

  logic [EW-1:0]          len_e;
  logic [CW-1:0]          len_eff;
  logic                   in_acc;
  logic                   cfg_acc;
  logic                   peak_done;
  logic                   div_last;
  logic                   out_free;

  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [TW-1:0]          alu_a;
  logic [TW-1:0]          alu_b;
  logic [TW-1:0]          alu_y;
  logic                   alu_co;

  // 0 acts as 1, above the ring depth acts as the depth
  assign len_e = EW'(len_r);
  always_comb begin
    if (len_r == '0) begin
      len_eff = CW'(1);
    end else if (len_e > EW'(WINDOW_MAX)) begin
      len_eff = CW'(WINDOW_MAX);
    end else begin
      len_eff = CW'(len_r);
    end
  end

  assign in_acc    = in_tvalid & in_tready;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign peak_done = (issue_r == fill_r) & ~pend_r;
  assign div_last  = (step_r == SW'(DW - 1));
  assign out_free  = ~out_valid_r | out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (fill_r >= len_eff) ? ST_DROP_RD : ST_WRITE;
        end
      end
      ST_DROP_RD:  state_nxt = ST_DROP_SUB;
      ST_DROP_SUB: state_nxt = ST_WRITE;
      ST_WRITE:    state_nxt = ST_PEAK;
      ST_PEAK: begin
        if (peak_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ctrl.op     = ALU_SUB;
    ctrl.mem_we = 1'b0;
    in_tready   = 1'b0;
    cfg_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = ~cfg_valid;
        cfg_ready = 1'b1;
      end
      ST_WRITE: begin
        ctrl.op     = ALU_ADD;
        ctrl.mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    alu_a = total_r;
    alu_b = TW'(rdata);
    unique case (state_r)
      ST_WRITE: alu_b = TW'(sample_r);
      ST_PEAK:  alu_a = TW'(peak_r);
      ST_DIV: begin
        alu_a = TW'({rem_r, q_r[DW-1]});
        alu_b = TW'(fill_r);
      end
      default: ;
    endcase
  end

  assign waddr = wrap_idx(PW'(head_r) + PW'(fill_r));
  assign raddr = (state_r == ST_PEAK) ? wrap_idx(PW'(head_r) + PW'(issue_r)) : head_r;

  swmp_ring #(
    .DEPTH (WINDOW_MAX),
    .AW    (AW),
    .DW    (SAMPLE_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (ctrl.mem_we),
    .waddr (waddr),
    .wdata (sample_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  swmp_alu #(
    .W (TW)
  ) u_alu (
    .op (ctrl.op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y),
    .co (alu_co)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LEN_RESET;
      head_r      <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        len_r   <= cfg_data;
        head_r  <= '0;
        fill_r  <= '0;
        total_r <= '0;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_DROP_SUB: begin
          total_r <= alu_y;
          head_r  <= (head_r == AW'(WINDOW_MAX - 1)) ? '0 : head_r + AW'(1);
          fill_r  <= fill_r - CW'(1);
        end
        ST_WRITE: begin
          total_r <= alu_y;
          fill_r  <= fill_r + CW'(1);
          issue_r <= '0;
          pend_r  <= 1'b0;
          first_r <= 1'b1;
        end
        ST_PEAK: begin
          // one read issued per cycle, its data compared when the registered read returns
          pend_r <= (issue_r != fill_r);
          if (issue_r != fill_r) begin
            issue_r <= issue_r + CW'(1);
          end
          if (pend_r) begin
            first_r <= 1'b0;
          end
          step_r <= '0;
        end
        ST_DIV: begin
          step_r <= step_r + SW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_tdata[SAMPLE_BITS-1:0];
    end
    unique case (state_r)
      ST_WRITE: begin
        peak_r <= '0;
      end
      ST_PEAK: begin
        if (pend_r) begin
          if (alu_co) begin
            peak_r <= rdata;
          end
          if (first_r) begin
            oldest_r <= rdata;
          end
        end
        if (peak_done) begin
          rem_r <= '0;
          q_r   <= {total_r, FRAC_BITS'(0)};
        end
      end
      ST_DIV: begin
        // restoring divide step: keep the difference when no borrow
        if (alu_co) begin
          rem_r <= CW'(alu_a);
          q_r   <= {q_r[DW-2:0], 1'b0};
        end else begin
          rem_r <= CW'(alu_y);
          q_r   <= {q_r[DW-2:0], 1'b1};
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r <= {sample_r, oldest_r, peak_r, q_r[MW-1:0], fill_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'(out_data_r);

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_eff)
    else $error("window fill above its length");

  a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (fill_r == '0) && (total_r == '0) && (head_r == '0))
    else $error("length write did not empty the window");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (total_r == '0))
    else $error("empty window with nonzero total");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside the finish step");

endmodule
`default_nettype wire
